@@ sv/single_pass_pixel_labeler_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the pixel labeler
// Concurrent assertion wrappers clocked on clk; compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef SINGLE_PASS_PIXEL_LABELER_ASSERT_SVH
`define SINGLE_PASS_PIXEL_LABELER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// checked only out of reset
`define SPL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked at every edge, reset included
`define SPL_ASSERT_NR(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPL_ASSERT(lbl, prop, msg)
`define SPL_ASSERT_NR(lbl, prop, msg)
`endif

`endif

@@ sv/spl_pkg.sv @@
// ----------------------------------------------------------------------------
// spl_pkg
// Shared types and constants of the single pass pixel labeler.
// ----------------------------------------------------------------------------
package spl_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int LABEL_BITS_DEF = 16;

	localparam int COLOUR_W    = 8;
	localparam int PIXEL_W     = 3 * COLOUR_W;
	localparam int THRESHOLD_W = 9;
	localparam int WIDTH_REG_W = 11;

	localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 9'd128;
	localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET     = 11'd640;

	// brightness is the mean of three components
	localparam int BRIGHT_DIV = 3;

	// register map: byte address 4 * index
	localparam int REG_IDX_W = 1;
	localparam int APB_AW    = REG_IDX_W + 2;
	localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_WIDTH     = 1'd1;

	localparam int FIFO_DEPTH = 2;

	typedef struct packed {
		logic [THRESHOLD_W-1:0] threshold;
		logic [WIDTH_REG_W-1:0] image_width;
	} cfg_t;

	// classification of one pixel, front to back
	typedef struct packed {
		logic frame_start;
		logic first_row;
		logic col_zero;
		logic last;
		logic fg;
	} pix_flags_t;

endpackage

@@ sv/spl_regs.sv @@
// ----------------------------------------------------------------------------
// spl_regs
// APB register file: threshold and image width.
// ----------------------------------------------------------------------------
module spl_regs import spl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [THRESHOLD_W-1:0] threshold_q;
	logic [WIDTH_REG_W-1:0] width_q;
	logic                   wr_en;
	logic [REG_IDX_W-1:0]   reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[APB_AW-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
			width_q     <= WIDTH_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_THRESHOLD: threshold_q <= pwdata[THRESHOLD_W-1:0];
				REG_WIDTH:     width_q     <= pwdata[WIDTH_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_THRESHOLD: prdata = 32'(threshold_q);
			REG_WIDTH:     prdata = 32'(width_q);
			default:       prdata = '0;
		endcase
	end

	assign cfg.threshold   = threshold_q;
	assign cfg.image_width = width_q;

endmodule

@@ sv/spl_front.sv @@
// ----------------------------------------------------------------------------
// spl_front
// Accepts pixels, tracks raster position and classifies foreground.
// ----------------------------------------------------------------------------
module spl_front import spl_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	localparam int CW = $clog2(MAX_WIDTH)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic [PIXEL_W-1:0] s_tdata,   // red, green, blue
	input  logic               s_tuser,   // frame_start
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic               fifo_full,
	output logic               push,
	output logic [CW-1:0]      push_col,
	output pix_flags_t         push_flags
);

	localparam int WW = (CW + 1 > WIDTH_REG_W) ? CW + 1 : WIDTH_REG_W;

	logic [CW-1:0]   col_q;
	logic            first_q;
	logic [WW-1:0]   w_cfg, w_eff, col_ext, col_clamp;
	logic [CW-1:0]   col;
	logic            last, first;
	logic [9:0]      sum;
	logic [10:0]     thr_x3;

	assign s_tready = !fifo_full;
	assign push     = s_tvalid && s_tready;

	always_comb begin
		w_cfg = WW'(cfg.image_width);
		if (w_cfg == '0)
			w_eff = WW'(1);
		else if (w_cfg > WW'(MAX_WIDTH))
			w_eff = WW'(MAX_WIDTH);
		else
			w_eff = w_cfg;
	end

	// a narrowed width ends the row at the new last column
	assign col_ext   = s_tuser ? '0 : WW'(col_q);
	assign col_clamp = (col_ext >= w_eff) ? w_eff - WW'(1) : col_ext;
	assign col       = col_clamp[CW-1:0];
	assign last      = (col_clamp + WW'(1)) >= w_eff;
	assign first     = s_tuser || first_q;

	// floor(sum / 3) >= t  <=>  sum >= 3t
	assign sum    = 10'(s_tdata[7:0]) + 10'(s_tdata[15:8]) + 10'(s_tdata[23:16]);
	assign thr_x3 = 11'(cfg.threshold) * 11'(BRIGHT_DIV);

	assign push_col               = col;
	assign push_flags.frame_start = s_tuser;
	assign push_flags.first_row   = first;
	assign push_flags.col_zero    = (col == '0);
	assign push_flags.last        = last;
	assign push_flags.fg          = 11'(sum) >= thr_x3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			first_q <= 1'b1;
		end else if (push) begin
			if (last) begin
				col_q   <= '0;
				first_q <= 1'b0;
			end else begin
				col_q   <= col + CW'(1);
				first_q <= first;
			end
		end
	end

endmodule

@@ sv/spl_fifo.sv @@
// ----------------------------------------------------------------------------
// spl_fifo
// Short register queue between front and back; head is visible unregistered.
// ----------------------------------------------------------------------------
module spl_fifo import spl_pkg::*; #(
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] push_data,
	input  logic          pop,
	output logic [DW-1:0] head_data,
	output logic          head_valid,
	output logic          full
);

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int NW = $clog2(FIFO_DEPTH + 1);

	logic [DW-1:0] mem_q [FIFO_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [NW-1:0] count_q;

	assign head_data  = mem_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign full       = (count_q == NW'(FIFO_DEPTH));

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + NW'(1);
			else if (pop && !push)
				count_q <= count_q - NW'(1);
		end
	end

endmodule

@@ sv/spl_back.sv @@
// ----------------------------------------------------------------------------
// spl_back
// Line buffer lookup, neighbour selection, label allocation, output register.
// ----------------------------------------------------------------------------
`include "single_pass_pixel_labeler_assert.svh"

module spl_back import spl_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int LABEL_BITS = LABEL_BITS_DEF,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int OW = ((LABEL_BITS + 1 + 7) / 8) * 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  logic [CW-1:0] head_col,
	input  pix_flags_t    head_flags,
	output logic          pop,
	output logic [OW-1:0] m_tdata,   // label, label_overflow
	output logic          m_tvalid,
	input  logic          m_tready
);

	localparam logic [LABEL_BITS-1:0] LMAX = {LABEL_BITS{1'b1}};

	logic [LABEL_BITS-1:0] line_mem [MAX_WIDTH];

	logic [CW-1:0]         rd_addr0, rd_addr1;
	logic                  b_valid_s2;
	logic [CW-1:0]         col_s2;
	pix_flags_t            flags_s2;
	logic [LABEL_BITS-1:0] up_rd_s2, upr_rd_s2;

	logic [LABEL_BITS-1:0] next_q, left_q, ul_q;
	logic                  ov_q;

	logic                  m_valid_q;
	logic [LABEL_BITS-1:0] label_q;
	logic                  ovf_q;

	logic                  b_ready, b_leave;
	logic [LABEL_BITS-1:0] up, upr, nl, nl_next, lab;
	logic                  ov, ov_next, use_fresh;

	assign b_ready = !m_valid_q || m_tready;
	assign b_leave = b_valid_s2 && b_ready;
	assign pop     = head_valid && (!b_valid_s2 || b_ready);

	// up-right address may wrap on the last column; it is masked then
	assign rd_addr0 = head_col;
	assign rd_addr1 = head_col + CW'(1);

	// read at the pop edge; the item leaving s2 writes at that same edge, so bypass it
	always_ff @(posedge clk) begin
		if (pop) begin
			up_rd_s2  <= (b_leave && col_s2 == rd_addr0) ? lab : line_mem[rd_addr0];
			upr_rd_s2 <= (b_leave && col_s2 == rd_addr1) ? lab : line_mem[rd_addr1];
			col_s2    <= head_col;
			flags_s2  <= head_flags;
		end
		if (b_leave)
			line_mem[col_s2] <= lab;
	end

	always_comb begin
		up        = flags_s2.first_row ? '0 : up_rd_s2;
		upr       = (flags_s2.first_row || flags_s2.last) ? '0 : upr_rd_s2;
		nl        = flags_s2.frame_start ? LABEL_BITS'(1) : next_q;
		ov        = flags_s2.frame_start ? 1'b0 : ov_q;
		lab       = '0;
		use_fresh = 1'b0;
		if (flags_s2.fg) begin
			if (flags_s2.first_row) begin
				if (!flags_s2.col_zero && left_q != '0) lab = left_q;
				else                                    use_fresh = 1'b1;
			end else if (flags_s2.col_zero) begin
				if (up != '0)       lab = up;
				else if (upr != '0) lab = upr;
				else                use_fresh = 1'b1;
			end else begin
				if (up != '0)          lab = up;
				else if (left_q != '0) lab = left_q;
				else if (ul_q != '0)   lab = ul_q;
				else if (upr != '0)    lab = upr;
				else                   use_fresh = 1'b1;
			end
		end
		nl_next = nl;
		ov_next = ov;
		if (use_fresh) begin
			lab = nl;
			// saturate: repeat the top label and flag it
			if (nl == LMAX) ov_next = 1'b1;
			else            nl_next = nl + LABEL_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_valid_s2 <= 1'b0;
			m_valid_q  <= 1'b0;
			next_q     <= LABEL_BITS'(1);
			ov_q       <= 1'b0;
			left_q     <= '0;
			ul_q       <= '0;
		end else begin
			if (pop)
				b_valid_s2 <= 1'b1;
			else if (b_leave)
				b_valid_s2 <= 1'b0;
			if (b_leave)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
			if (b_leave) begin
				next_q <= nl_next;
				ov_q   <= ov_next;
				left_q <= flags_s2.last ? '0 : lab;
				ul_q   <= flags_s2.last ? '0 : up;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (b_leave) begin
			label_q <= lab;
			ovf_q   <= ov_next;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OW'({ovf_q, label_q});

	`SPL_ASSERT(a_next_nonzero, next_q != '0, "label counter reached zero")
	`SPL_ASSERT(a_fg_labelled, b_leave |-> ((lab != '0) == flags_s2.fg), "label/foreground mismatch")
	`SPL_ASSERT(a_ovf_saturated, ov_q |-> (next_q == LMAX), "overflow without saturated counter")
	`SPL_ASSERT(a_pop_slot, pop |=> b_valid_s2, "popped item lost before s2")

endmodule

@@ sv/single_pass_pixel_labeler.sv @@
// ----------------------------------------------------------------------------
// single_pass_pixel_labeler
// Labels foreground pixels of a raster stream by neighbour copy, one pass.
// ----------------------------------------------------------------------------
// One pixel per clock, sustained while m_tready is high: the line buffer is
// read at two columns on every pop and written at one as a pixel leaves the
// lookup stage; neighbour selection plus label allocation finish in a single
// stage. From input transfer to output transfer a pixel passes the queue, the
// lookup stage and the output register. Assert s_tuser on the first pixel of
// every frame; the line buffer has no clearing pass and row 0 never uses it.
// Labels start at 1, are never merged, and the counter saturates at all ones
// with label_overflow set for the rest of the frame. Registers: threshold at
// 0x0, image_width at 0x4, written by the user between frames; not enforced.
module single_pass_pixel_labeler import spl_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int LABEL_BITS = LABEL_BITS_DEF,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int OW = ((LABEL_BITS + 1 + 7) / 8) * 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [APB_AW-1:0]  paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic [PIXEL_W-1:0] s_tdata,   // red, green, blue
	input  logic               s_tuser,   // frame_start
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic [OW-1:0]      m_tdata,   // label, label_overflow
	output logic               m_tvalid,
	input  logic               m_tready
);

	localparam int QW = CW + $bits(pix_flags_t);

	cfg_t          cfg;
	logic          fifo_full, push, pop, head_valid;
	logic [CW-1:0] push_col, head_col;
	pix_flags_t    push_flags, head_flags;
	logic [QW-1:0] head_data;

	spl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	spl_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.fifo_full  (fifo_full),
		.push       (push),
		.push_col   (push_col),
		.push_flags (push_flags)
	);

	spl_fifo #(.DW(QW)) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  ({push_col, push_flags}),
		.pop        (pop),
		.head_data  (head_data),
		.head_valid (head_valid),
		.full       (fifo_full)
	);

	assign head_col   = head_data[QW-1 -: CW];
	assign head_flags = pix_flags_t'(head_data[$bits(pix_flags_t)-1:0]);

	spl_back #(.MAX_WIDTH(MAX_WIDTH), .LABEL_BITS(LABEL_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_col   (head_col),
		.head_flags (head_flags),
		.pop        (pop),
		.m_tdata    (m_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready)
	);

endmodule
